// ----- design/idll_pkg.sv -----
// Shared types and codes for the indexed doubly linked list.
// Used by idll_plan, idll_link_store and the top level; depends on nothing.
package idll_pkg;

	// Beat field widths (fixed by the stream format).
	localparam int ACT_W    = 2;
	localparam int NODE_W   = 6;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 24;
	// Every code a node field can carry.
	localparam int FIELD_SLOTS = 2 ** NODE_W;
	// Link-table writes per item, per table.
	localparam int WR_SLOTS = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_MOVE   = 2'd2,
		ACT_NOP    = 2'd3
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Write enables of the planned link updates, one per write slot.
	typedef struct packed {
		logic [WR_SLOTS-1:0] prev_we;
		logic [WR_SLOTS-1:0] next_we;
	} idll_wen_t;

endpackage

// ----- design/idll_link_store.sv -----
// Previous and next link tables: one write port each, registered reads.
// The previous table has two read ports, the next table one. Uses idll_pkg.
module idll_link_store import idll_pkg::*; #(
	parameter int NODE_SLOTS = 64,
	parameter int SW = 6,
	parameter int LW = 7
) (
	input  logic          clk,
	input  logic          re,
	input  logic [SW-1:0] prev_raddr_a,
	input  logic [SW-1:0] prev_raddr_b,
	input  logic [SW-1:0] next_raddr,
	output logic [LW-1:0] prev_rdata_a,
	output logic [LW-1:0] prev_rdata_b,
	output logic [LW-1:0] next_rdata,
	input  logic          prev_we,
	input  logic [SW-1:0] prev_waddr,
	input  logic [LW-1:0] prev_wdata,
	input  logic          next_we,
	input  logic [SW-1:0] next_waddr,
	input  logic [LW-1:0] next_wdata
);

	logic [LW-1:0] prev_mem [NODE_SLOTS];
	logic [LW-1:0] next_mem [NODE_SLOTS];

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (re) begin
			prev_rdata_a <= prev_mem[prev_raddr_a];
			prev_rdata_b <= prev_mem[prev_raddr_b];
			next_rdata   <= next_mem[next_raddr];
		end
	end

endmodule

// ----- design/idll_plan.sv -----
// Works out, from the links read for one item, up to three writes per link
// table in program order plus the new front, back, count and status. Uses idll_pkg.
module idll_plan import idll_pkg::*; #(
	parameter int NODE_SLOTS = 64,
	parameter int SW = 6,
	parameter int LW = 7
) (
	input  act_t          act,
	input  logic [SW-1:0] item,
	input  logic [SW-1:0] place,
	input  logic          at_end,
	input  logic [LW-1:0] item_prev,
	input  logic [LW-1:0] item_next,
	input  logic [LW-1:0] place_prev,
	input  logic [LW-1:0] front,
	input  logic [LW-1:0] back,
	input  logic [LW-1:0] count,
	output status_t       status,
	output logic [LW-1:0] front_n,
	output logic [LW-1:0] back_n,
	output logic [LW-1:0] count_n,
	output idll_wen_t     wen,
	output logic [SW-1:0] prev_wa [WR_SLOTS],
	output logic [LW-1:0] prev_wd [WR_SLOTS],
	output logic [SW-1:0] next_wa [WR_SLOTS],
	output logic [LW-1:0] next_wd [WR_SLOTS]
);

	localparam logic [LW-1:0] LINK_NONE = LW'(NODE_SLOTS);

	logic [LW-1:0] item_l;
	logic [LW-1:0] place_l;
	logic [LW-1:0] pp;
	logic [LW-1:0] front_mv;

	function automatic logic vld(input logic [LW-1:0] x);
		return x < LINK_NONE;
	endfunction

	assign item_l  = LW'(item);
	assign place_l = LW'(place);
	// prev of place as seen after the unlink wrote prev[next of item]
	assign pp = (vld(item_next) && item_next == place_l) ? item_prev : place_prev;
	assign front_mv = (item_l == front) ? item_next : front;

	always_comb begin
		status  = ST_DONE;
		front_n = front;
		back_n  = back;
		count_n = count;
		wen     = '0;
		for (int i = 0; i < WR_SLOTS; i++) begin
			prev_wa[i] = item;
			prev_wd[i] = LINK_NONE;
			next_wa[i] = item;
			next_wd[i] = LINK_NONE;
		end
		unique case (act)
			ACT_INSERT: begin
				if (count >= LINK_NONE) begin
					status = ST_FULL;
				end else if (!at_end) begin
					if (count == '0) begin
						status = ST_EMPTY;
					end else begin
						wen.prev_we[0] = 1'b1;
						prev_wd[0]     = place_prev;
						wen.prev_we[1] = 1'b1;
						prev_wa[1]     = place;
						prev_wd[1]     = item_l;
						wen.next_we[0] = 1'b1;
						next_wd[0]     = place_l;
						wen.next_we[1] = vld(place_prev);
						next_wa[1]     = place_prev[SW-1:0];
						next_wd[1]     = item_l;
						if (place != item && !vld(place_prev)) begin
							front_n = item_l;
						end
						count_n = count + 1'b1;
					end
				end else begin
					wen.next_we[0] = vld(back);
					next_wa[0]     = back[SW-1:0];
					next_wd[0]     = item_l;
					wen.next_we[1] = 1'b1;
					wen.prev_we[0] = 1'b1;
					prev_wd[0]     = back;
					back_n = item_l;
					if (!vld(back)) begin
						front_n = item_l;
					end
					count_n = count + 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (count == '0) begin
					status = ST_EMPTY;
				end else begin
					wen.next_we[0] = vld(item_prev);
					next_wa[0]     = item_prev[SW-1:0];
					next_wd[0]     = item_next;
					wen.next_we[1] = 1'b1;
					wen.prev_we[0] = vld(item_next);
					prev_wa[0]     = item_next[SW-1:0];
					prev_wd[0]     = item_prev;
					wen.prev_we[1] = 1'b1;
					if (!vld(item_prev)) begin
						front_n = item_next;
					end
					if (!vld(item_next)) begin
						back_n = item_prev;
					end
					count_n = count - 1'b1;
				end
			end
			ACT_MOVE: begin
				if (count == '0) begin
					status = ST_EMPTY;
				end else if ((!at_end && item == place) || (at_end && back == item_l)) begin
					status = ST_DONE;
				end else begin
					// unlink
					wen.next_we[0] = vld(item_prev);
					next_wa[0]     = item_prev[SW-1:0];
					next_wd[0]     = item_next;
					wen.prev_we[0] = vld(item_next);
					prev_wa[0]     = item_next[SW-1:0];
					prev_wd[0]     = item_prev;
					if (at_end) begin
						wen.prev_we[1] = 1'b1;
						prev_wd[1]     = back;
						wen.next_we[1] = 1'b1;
						wen.next_we[2] = vld(back);
						next_wa[2]     = back[SW-1:0];
						next_wd[2]     = item_l;
						front_n = front_mv;
						back_n  = item_l;
					end else begin
						wen.prev_we[1] = 1'b1;
						prev_wd[1]     = pp;
						wen.prev_we[2] = 1'b1;
						prev_wa[2]     = place;
						prev_wd[2]     = item_l;
						wen.next_we[1] = 1'b1;
						next_wd[1]     = place_l;
						wen.next_we[2] = vld(pp);
						next_wa[2]     = pp[SW-1:0];
						next_wd[2]     = item_l;
						front_n = vld(pp) ? front_mv : item_l;
						back_n  = (item_l == back) ? item_prev : back;
					end
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

endmodule

// ----- design/indexed_doubly_linked_list.sv -----
// Indexed doubly linked list over a pool of NODE_SLOTS slots; top level.
// Depends on idll_pkg, idll_link_store and idll_plan.
// Each input beat passes through S_PLAN, S_WR1 and S_WR2; the result beat is
// registered in S_WR2 once the output register is free. A new item is taken
// only in S_IDLE. Up to three link writes per table use its single write port.
// Reset: front and back read as none, count as zero; link tables are not
// cleared, and an entry is defined once it is written.
module indexed_doubly_linked_list import idll_pkg::*; #(
	parameter int NODE_SLOTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// [1:0] action, [7:2] item_node, [13:8] place_node, [14] place_is_end, [15] zero
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// [1:0] status, [8:2] node_count, [14:9] front_node, [15] front_none,
	// [21:16] back_node, [22] back_none, [23] zero
	output logic [OUT_W-1:0] m_tdata
);

	localparam int SW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int LW = $clog2(NODE_SLOTS + 1);
	localparam logic [LW-1:0] LINK_NONE = LW'(NODE_SLOTS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PLAN,
		S_WR1,
		S_WR2
	} state_t;

	state_t        state_q;
	logic          accept;
	logic [SW-1:0] slot_tab [FIELD_SLOTS];
	logic [SW-1:0] in_item;
	logic [SW-1:0] in_place;

	act_t          act_q;
	logic [SW-1:0] item_q;
	logic [SW-1:0] place_q;
	logic          at_end_q;

	logic [LW-1:0] front_q;
	logic [LW-1:0] back_q;
	logic [LW-1:0] count_q;
	status_t       status_q;
	idll_wen_t     wen_q;

	logic [LW-1:0] item_prev;
	logic [LW-1:0] place_prev;
	logic [LW-1:0] item_next;

	status_t       plan_status;
	logic [LW-1:0] plan_front;
	logic [LW-1:0] plan_back;
	logic [LW-1:0] plan_count;
	idll_wen_t     plan_wen;
	logic [SW-1:0] plan_prev_wa [WR_SLOTS];
	logic [LW-1:0] plan_prev_wd [WR_SLOTS];
	logic [SW-1:0] plan_next_wa [WR_SLOTS];
	logic [LW-1:0] plan_next_wd [WR_SLOTS];
	logic [SW-1:0] prev_wa_q [WR_SLOTS];
	logic [LW-1:0] prev_wd_q [WR_SLOTS];
	logic [SW-1:0] next_wa_q [WR_SLOTS];
	logic [LW-1:0] next_wd_q [WR_SLOTS];

	logic          prev_we;
	logic [SW-1:0] prev_waddr;
	logic [LW-1:0] prev_wdata;
	logic          next_we;
	logic [SW-1:0] next_waddr;
	logic [LW-1:0] next_wdata;

	logic              front_none;
	logic              back_none;
	logic [OUT_W-1:0]  result;
	logic              out_load;

	// Field code to slot: wraps codes at or above the pool size.
	for (genvar g = 0; g < FIELD_SLOTS; g++) begin : g_slot
		assign slot_tab[g] = SW'(g % NODE_SLOTS);
	end

	assign in_item  = slot_tab[s_tdata[ACT_W +: NODE_W]];
	assign in_place = slot_tab[s_tdata[ACT_W+NODE_W +: NODE_W]];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= act_t'(s_tdata[ACT_W-1:0]);
			item_q   <= in_item;
			place_q  <= in_place;
			at_end_q <= s_tdata[ACT_W+2*NODE_W];
		end
		if (state_q == S_PLAN) begin
			prev_wa_q <= plan_prev_wa;
			prev_wd_q <= plan_prev_wd;
			next_wa_q <= plan_next_wa;
			next_wd_q <= plan_next_wd;
		end
	end

	idll_link_store #(
		.NODE_SLOTS(NODE_SLOTS),
		.SW(SW),
		.LW(LW)
	) u_store (
		.clk         (clk),
		.re          (accept),
		.prev_raddr_a(in_item),
		.prev_raddr_b(in_place),
		.next_raddr  (in_item),
		.prev_rdata_a(item_prev),
		.prev_rdata_b(place_prev),
		.next_rdata  (item_next),
		.prev_we     (prev_we),
		.prev_waddr  (prev_waddr),
		.prev_wdata  (prev_wdata),
		.next_we     (next_we),
		.next_waddr  (next_waddr),
		.next_wdata  (next_wdata)
	);

	idll_plan #(
		.NODE_SLOTS(NODE_SLOTS),
		.SW(SW),
		.LW(LW)
	) u_plan (
		.act       (act_q),
		.item      (item_q),
		.place     (place_q),
		.at_end    (at_end_q),
		.item_prev (item_prev),
		.item_next (item_next),
		.place_prev(place_prev),
		.front     (front_q),
		.back      (back_q),
		.count     (count_q),
		.status    (plan_status),
		.front_n   (plan_front),
		.back_n    (plan_back),
		.count_n   (plan_count),
		.wen       (plan_wen),
		.prev_wa   (plan_prev_wa),
		.prev_wd   (plan_prev_wd),
		.next_wa   (plan_next_wa),
		.next_wd   (plan_next_wd)
	);

	// Slot 0 writes straight from the plan; slots 1 and 2 from its copy.
	always_comb begin
		prev_we    = 1'b0;
		prev_waddr = '0;
		prev_wdata = '0;
		next_we    = 1'b0;
		next_waddr = '0;
		next_wdata = '0;
		unique case (state_q)
			S_PLAN: begin
				prev_we    = plan_wen.prev_we[0];
				prev_waddr = plan_prev_wa[0];
				prev_wdata = plan_prev_wd[0];
				next_we    = plan_wen.next_we[0];
				next_waddr = plan_next_wa[0];
				next_wdata = plan_next_wd[0];
			end
			S_WR1: begin
				prev_we    = wen_q.prev_we[1];
				prev_waddr = prev_wa_q[1];
				prev_wdata = prev_wd_q[1];
				next_we    = wen_q.next_we[1];
				next_waddr = next_wa_q[1];
				next_wdata = next_wd_q[1];
			end
			S_WR2: begin
				prev_we    = wen_q.prev_we[2];
				prev_waddr = prev_wa_q[2];
				prev_wdata = prev_wd_q[2];
				next_we    = wen_q.next_we[2];
				next_waddr = next_wa_q[2];
				next_wdata = next_wd_q[2];
			end
			default: begin
				prev_we = 1'b0;
				next_we = 1'b0;
			end
		endcase
	end

	assign front_none = !(front_q < LINK_NONE);
	assign back_none  = !(back_q < LINK_NONE);
	assign result = {
		1'b0,
		back_none,
		back_none ? {NODE_W{1'b0}} : NODE_W'(back_q),
		front_none,
		front_none ? {NODE_W{1'b0}} : NODE_W'(front_q),
		COUNT_W'(count_q),
		status_q
	};

	assign out_load = (state_q == S_WR2) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= LINK_NONE;
			back_q   <= LINK_NONE;
			count_q  <= '0;
			status_q <= ST_DONE;
			wen_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= result;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					front_q  <= plan_front;
					back_q   <= plan_back;
					count_q  <= plan_count;
					status_q <= plan_status;
					wen_q    <= plan_wen;
					state_q  <= S_WR1;
				end
				S_WR1: begin
					state_q <= S_WR2;
				end
				S_WR2: begin
					// hold the last write until the output register frees up
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Reads at accept rely on every link write of the previous item being done.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!prev_we && !next_we))
		else $error("link write while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LINK_NONE)
		else $error("count above pool size");

	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLAN && plan_status != ST_DONE) |=>
		(count_q == $past(count_q) && front_q == $past(front_q) && back_q == $past(back_q)))
		else $error("error status changed list pointers");

	a_full_only_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLAN && plan_status == ST_FULL) |-> (count_q == LINK_NONE))
		else $error("full status below pool size");

endmodule
